[rtl/akrb_pkg.sv]
package akrb_pkg;

    localparam int DIM_W      = 11;
    localparam int OFS_W      = 10;
    localparam int ALPHA_W    = 9;
    localparam int INDEX_W    = 20;
    localparam int PIXEL_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_WIDTH    = 3'd0,
        REG_DEST_HEIGHT   = 3'd1,
        REG_SOURCE_WIDTH  = 3'd2,
        REG_SOURCE_HEIGHT = 3'd3,
        REG_OFFSET_X      = 3'd4,
        REG_OFFSET_Y      = 3'd5,
        REG_ALPHA_REF     = 3'd6,
        REG_ROTATE        = 3'd7
    } reg_idx_t;

    // configuration fields; akrb_cfg clamps dimensions to the legal range
    typedef struct packed {
        logic [DIM_W-1:0]   dest_width;
        logic [DIM_W-1:0]   dest_height;
        logic [DIM_W-1:0]   source_width;
        logic [DIM_W-1:0]   source_height;
        logic [OFS_W-1:0]   offset_x;
        logic [OFS_W-1:0]   offset_y;
        logic [ALPHA_W-1:0] alpha_ref;
        logic               rotate;
    } cfg_t;

    typedef struct packed {
        logic write_enable;
        logic end_of_source;
        logic fit_error;
    } flags_t;

endpackage

[rtl/akrb_cfg.sv]
module akrb_cfg #(
    parameter int MAX_DIM = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [akrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [akrb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output akrb_pkg::cfg_t                    cfg
);

    logic [akrb_pkg::DIM_W-1:0]   dest_width_reg;
    logic [akrb_pkg::DIM_W-1:0]   dest_height_reg;
    logic [akrb_pkg::DIM_W-1:0]   source_width_reg;
    logic [akrb_pkg::DIM_W-1:0]   source_height_reg;
    logic [akrb_pkg::OFS_W-1:0]   offset_x_reg;
    logic [akrb_pkg::OFS_W-1:0]   offset_y_reg;
    logic [akrb_pkg::ALPHA_W-1:0] alpha_ref_reg;
    logic                         rotate_reg;

    // zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [akrb_pkg::DIM_W-1:0] eff_dim(input logic [akrb_pkg::DIM_W-1:0] v);
        logic [akrb_pkg::DIM_W-1:0] r;
        if (v == '0)
        begin
            r = akrb_pkg::DIM_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = akrb_pkg::DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg    <= akrb_pkg::DIM_W'(1024);
            dest_height_reg   <= akrb_pkg::DIM_W'(1024);
            source_width_reg  <= akrb_pkg::DIM_W'(1);
            source_height_reg <= akrb_pkg::DIM_W'(1);
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            alpha_ref_reg     <= '0;
            rotate_reg        <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (akrb_pkg::reg_idx_t'(cfg_index))
                akrb_pkg::REG_DEST_WIDTH:    dest_width_reg    <= cfg_data[akrb_pkg::DIM_W-1:0];
                akrb_pkg::REG_DEST_HEIGHT:   dest_height_reg   <= cfg_data[akrb_pkg::DIM_W-1:0];
                akrb_pkg::REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[akrb_pkg::DIM_W-1:0];
                akrb_pkg::REG_SOURCE_HEIGHT: source_height_reg <= cfg_data[akrb_pkg::DIM_W-1:0];
                akrb_pkg::REG_OFFSET_X:      offset_x_reg      <= cfg_data[akrb_pkg::OFS_W-1:0];
                akrb_pkg::REG_OFFSET_Y:      offset_y_reg      <= cfg_data[akrb_pkg::OFS_W-1:0];
                akrb_pkg::REG_ALPHA_REF:     alpha_ref_reg     <= cfg_data[akrb_pkg::ALPHA_W-1:0];
                akrb_pkg::REG_ROTATE:        rotate_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.dest_width    = eff_dim(dest_width_reg);
        cfg.dest_height   = eff_dim(dest_height_reg);
        cfg.source_width  = eff_dim(source_width_reg);
        cfg.source_height = eff_dim(source_height_reg);
        cfg.offset_x      = offset_x_reg;
        cfg.offset_y      = offset_y_reg;
        cfg.alpha_ref     = alpha_ref_reg;
        cfg.rotate        = rotate_reg;
    end

endmodule

[rtl/akrb_addr.sv]
module akrb_addr #(
    parameter int MAX_DIM = 1024,
    localparam int CW     = $clog2(MAX_DIM),
    localparam int PW     = ((CW > akrb_pkg::OFS_W) ? CW : akrb_pkg::OFS_W) + 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  akrb_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [akrb_pkg::PIXEL_W-1:0]     source_pixel,
    output logic                             a_valid,
    input  logic                             a_stall,
    output logic [akrb_pkg::PIXEL_W-1:0]     a_pixel,
    output logic [PW-1:0]                    a_dx,
    output logic [PW-1:0]                    a_dy,
    output akrb_pkg::flags_t                 a_flags
);

    localparam int CMP_W = ((CW > akrb_pkg::DIM_W) ? CW : akrb_pkg::DIM_W) + 1;
    localparam int FW    = akrb_pkg::DIM_W + 1;

    logic                          a_valid_reg, a_valid_next;
    logic [CW-1:0]                 col_reg, col_next;
    logic [CW-1:0]                 row_reg, row_next;
    logic [akrb_pkg::PIXEL_W-1:0]  pixel_reg;
    logic [PW-1:0]                 dx_reg, dx_next;
    logic [PW-1:0]                 dy_reg, dy_next;
    akrb_pkg::flags_t              flags_reg, flags_next;

    logic             load;
    logic [CMP_W-1:0] col_inc, row_inc;
    logic             last_col, last_row;
    logic [FW-1:0]    span_x, span_y;
    logic             fits, pass;

    assign in_stall = a_valid_reg && a_stall;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        row_inc  = CMP_W'(row_reg) + CMP_W'(1);
        // a counter at or past a shrunken limit counts as the last position
        last_col = col_inc >= CMP_W'(cfg.source_width);
        last_row = row_inc >= CMP_W'(cfg.source_height);

        if (cfg.rotate)
        begin
            span_x  = FW'(cfg.offset_x) + FW'(cfg.source_height);
            span_y  = FW'(cfg.offset_y) + FW'(cfg.source_width);
            dx_next = PW'(cfg.offset_x) + PW'(row_reg);
            dy_next = PW'(cfg.offset_y) + PW'(col_reg);
        end
        else
        begin
            span_x  = FW'(cfg.offset_x) + FW'(cfg.source_width);
            span_y  = FW'(cfg.offset_y) + FW'(cfg.source_height);
            dx_next = PW'(cfg.offset_x) + PW'(col_reg);
            dy_next = PW'(cfg.offset_y) + PW'(row_reg);
        end
        fits = (span_x <= FW'(cfg.dest_width)) && (span_y <= FW'(cfg.dest_height));
        pass = {1'b0, source_pixel[31:24]} >= cfg.alpha_ref;

        flags_next.write_enable  = pass && fits;
        flags_next.end_of_source = last_col && last_row;
        flags_next.fit_error     = !fits;

        col_next = col_reg;
        row_next = row_reg;
        if (load)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[CW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end

        if (load)
        begin
            a_valid_next = 1'b1;
        end
        else
        begin
            a_valid_next = a_valid_reg && a_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= source_pixel;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            flags_reg <= flags_next;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_pixel = pixel_reg;
    assign a_dx    = dx_reg;
    assign a_dy    = dy_reg;
    assign a_flags = flags_reg;

    // the last pixel of the rectangle wraps both counters
    a_eos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        load && flags_next.end_of_source |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters did not wrap after end of source");

    // counters move only on an accepted pixel
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(col_reg) && $stable(row_reg))
        else $error("source counters moved without a transaction");

endmodule

[rtl/akrb_index.sv]
module akrb_index #(
    parameter int MAX_DIM = 1024,
    localparam int CW     = $clog2(MAX_DIM),
    localparam int PW     = ((CW > akrb_pkg::OFS_W) ? CW : akrb_pkg::OFS_W) + 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [akrb_pkg::DIM_W-1:0]       dest_width_eff,
    input  logic                             a_valid,
    output logic                             a_stall,
    input  logic [akrb_pkg::PIXEL_W-1:0]     a_pixel,
    input  logic [PW-1:0]                    a_dx,
    input  logic [PW-1:0]                    a_dy,
    input  akrb_pkg::flags_t                 a_flags,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             write_enable,
    output logic [akrb_pkg::INDEX_W-1:0]     dest_index,
    output logic [akrb_pkg::PIXEL_W-1:0]     pixel_out,
    output logic                             end_of_source,
    output logic                             fit_error
);

    localparam int PRODW = PW + akrb_pkg::DIM_W + 1;

    logic                          out_valid_reg, out_valid_next;
    logic [akrb_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [akrb_pkg::PIXEL_W-1:0]  pixel_reg;
    akrb_pkg::flags_t              flags_reg;
    logic                          take;

    assign a_stall = out_valid_reg && out_stall;
    assign take    = a_valid && !a_stall;

    // row times row length plus column, kept to the index width
    always_comb
    begin
        index_next = akrb_pkg::INDEX_W'(PRODW'(a_dy) * PRODW'(dest_width_eff) + PRODW'(a_dx));
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            index_reg <= index_next;
            pixel_reg <= a_pixel;
            flags_reg <= a_flags;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = flags_reg.write_enable;
    assign dest_index    = index_reg;
    assign pixel_out     = pixel_reg;
    assign end_of_source = flags_reg.end_of_source;
    assign fit_error     = flags_reg.fit_error;

    // a transaction taken from the first stage shows up at the output
    a_take_out: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("taken pixel did not reach the output register");

    // a write is never enabled while the placement is out of bounds
    a_we_fit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(flags_reg.write_enable && flags_reg.fit_error))
        else $error("write enabled despite fit error");

endmodule

[rtl/alpha_keyed_rect_blit_core.sv]
// alpha keyed rectangle blit core
// source pixels (32-bit argb, alpha in bits 31..24) enter in raster order on the
// in channel (in_valid / in_stall / source_pixel). each one gives exactly one
// result on the out channel (out_valid / out_stall): the linear destination
// index, the pixel itself, a write enable, an end-of-source mark on the last
// pixel of the rectangle and a fit error flag when the placed rectangle
// (offset plus source size, transposed in rotate mode) leaves the destination.
// configuration goes through cfg_valid / cfg_ready / cfg_index / cfg_data;
// cfg_ready is always high, so a write completes in the cycle it is offered.
// the user must write registers only while no transaction is in flight;
// the block does not enforce this. a pixel taken on the in channel passes one
// register stage for counters, coordinates and flags, then the result register
// behind the row multiply-add before it is offered on the out channel.
// throughput: one pixel per cycle while out_stall is low, set by the single
// multiply-add stage. a stalled output holds its result; the first stage keeps
// accepting until it is also full, then in_stall rises in the same cycle.
// reset clears both source counters and loads the register defaults (1024 x 1024
// destination, 1 x 1 source, no offset, alpha reference 0, straight copy).
module alpha_keyed_rect_blit_core #(
    parameter int MAX_DIM = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [akrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [akrb_pkg::CFG_DATA_W-1:0]   cfg_data,
    // source pixel channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [akrb_pkg::PIXEL_W-1:0]      source_pixel,
    // destination write channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              write_enable,
    output logic [akrb_pkg::INDEX_W-1:0]      dest_index,
    output logic [akrb_pkg::PIXEL_W-1:0]      pixel_out,
    output logic                              end_of_source,
    output logic                              fit_error
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int PW = ((CW > akrb_pkg::OFS_W) ? CW : akrb_pkg::OFS_W) + 1;

    akrb_pkg::cfg_t                cfg;
    logic                          a_valid;
    logic                          a_stall;
    logic [akrb_pkg::PIXEL_W-1:0]  a_pixel;
    logic [PW-1:0]                 a_dx;
    logic [PW-1:0]                 a_dy;
    akrb_pkg::flags_t              a_flags;

    // register writes never wait
    assign cfg_ready = 1'b1;

    akrb_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage one: raster counters, placed coordinates, alpha test, fit check
    akrb_addr #(
        .MAX_DIM (MAX_DIM)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_pixel (source_pixel),
        .a_valid      (a_valid),
        .a_stall      (a_stall),
        .a_pixel      (a_pixel),
        .a_dx         (a_dx),
        .a_dy         (a_dy),
        .a_flags      (a_flags)
    );

    // stage two: row times destination width plus column into the result register
    akrb_index #(
        .MAX_DIM (MAX_DIM)
    ) u_index (
        .clk            (clk),
        .rst_n          (rst_n),
        .dest_width_eff (cfg.dest_width),
        .a_valid        (a_valid),
        .a_stall        (a_stall),
        .a_pixel        (a_pixel),
        .a_dx           (a_dx),
        .a_dy           (a_dy),
        .a_flags        (a_flags),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .write_enable   (write_enable),
        .dest_index     (dest_index),
        .pixel_out      (pixel_out),
        .end_of_source  (end_of_source),
        .fit_error      (fit_error)
    );

endmodule

[tb/sv/alpha_keyed_rect_blit_core_tb.sv]
`timescale 1ns / 100ps

module alpha_keyed_rect_blit_core_tb;

    localparam int MAX_DIM      = 1024;
    // one stage for counters and flags, one for the multiply-add, plus margin
    localparam int PIPE_LATENCY = 3;
    localparam int RANDOM_ITEMS = 450;

    // contents of one destination write transaction
    typedef struct packed {
        akrb_pkg::flags_t             flags;
        logic [akrb_pkg::INDEX_W-1:0] dest_index;
        logic [akrb_pkg::PIXEL_W-1:0] pixel;
    } dest_write_t;

    // register values right after reset
    localparam akrb_pkg::cfg_t RESET_REGS = '{
        dest_width:    11'd1024,
        dest_height:   11'd1024,
        source_width:  11'd1,
        source_height: 11'd1,
        offset_x:      10'd0,
        offset_y:      10'd0,
        alpha_ref:     9'd0,
        rotate:        1'b0
    };

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_valid    = 1'b0;
    logic                            cfg_ready;
    akrb_pkg::reg_idx_t              cfg_index    = akrb_pkg::REG_DEST_WIDTH;
    logic [akrb_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                            in_valid     = 1'b0;
    logic                            in_stall;
    logic [akrb_pkg::PIXEL_W-1:0]    source_pixel = '0;
    logic                            out_valid;
    logic                            out_stall    = 1'b0;
    logic                            write_enable;
    logic [akrb_pkg::INDEX_W-1:0]    dest_index;
    logic [akrb_pkg::PIXEL_W-1:0]    pixel_out;
    logic                            end_of_source;
    logic                            fit_error;

    // shadow of the register file, raw as written; clamping happens in place_pixel
    akrb_pkg::cfg_t blit_regs = RESET_REGS;
    // shadow of the raster position inside the source rectangle
    int unsigned src_col   = 0;
    int unsigned src_row   = 0;
    // destination writes predicted but not yet seen on the out channel
    dest_write_t pending_writes[$];
    int          fault_count = 0;

    // idling controls: sender gaps on/off, receiver stall 0 none, 1 light, 2 heavy
    bit          sender_gaps = 1'b0;
    int          stall_mode  = 0;
    int          stall_left  = 0;

    alpha_keyed_rect_blit_core #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .source_pixel(source_pixel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .write_enable(write_enable),
        .dest_index(dest_index),
        .pixel_out(pixel_out),
        .end_of_source(end_of_source),
        .fit_error(fit_error)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    // zero acts as one, anything past MAX_DIM acts as MAX_DIM
    function automatic int unsigned clamp_dim(input logic [akrb_pkg::DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (32'(v) > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // destination write for one source pixel, then step the raster position
    function automatic dest_write_t place_pixel(input logic [akrb_pkg::PIXEL_W-1:0] px);
        int unsigned dw, dh, sw, sh, ox, oy, dx, dy;
        logic        fits, last_col, last_row;
        dest_write_t w;
        dw = clamp_dim(blit_regs.dest_width);
        dh = clamp_dim(blit_regs.dest_height);
        sw = clamp_dim(blit_regs.source_width);
        sh = clamp_dim(blit_regs.source_height);
        ox = 32'(blit_regs.offset_x);
        oy = 32'(blit_regs.offset_y);
        if (blit_regs.rotate)
        begin
            // transposed: source rows run along destination columns
            fits = (ox + sh <= dw) && (oy + sw <= dh);
            dx   = ox + src_row;
            dy   = oy + src_col;
        end
        else
        begin
            fits = (ox + sw <= dw) && (oy + sh <= dh);
            dx   = ox + src_col;
            dy   = oy + src_row;
        end
        // a counter at or past a shrunken limit counts as the last position
        last_col = (src_col + 1 >= sw);
        last_row = (src_row + 1 >= sh);

        // index is still produced on a fit error, wrapped to the port width
        w.dest_index               = akrb_pkg::INDEX_W'(dy * dw + dx);
        w.pixel                    = px;
        w.flags.fit_error          = !fits;
        w.flags.write_enable       = fits && ({1'b0, px[31:24]} >= blit_regs.alpha_ref);
        w.flags.end_of_source      = last_col && last_row;

        if (last_col)
        begin
            src_col = 0;
            src_row = last_row ? 0 : src_row + 1;
        end
        else
            src_col = src_col + 1;
        return w;
    endfunction

    // append one prediction behind the ones still outstanding
    function automatic void queue_expected(input dest_write_t w);
        pending_writes = {pending_writes, w};
    endfunction

    // ---------------------------------------------------------------------
    // receiver side: random stalls, mostly short, a few long
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : stall_gen
        int r;
        r = $urandom_range(0, 99);
        if (stall_mode == 0)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (r < (stall_mode == 2 ? 40 : 70))
            out_stall <= 1'b0;
        else if (r < 96)
        begin
            out_stall  <= 1'b1;
            stall_left <= int'($urandom_range(0, 2));
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= int'($urandom_range(5, 30));
        end
    end

    // ---------------------------------------------------------------------
    // checker: every accepted out transaction against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : dest_write_check
        dest_write_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected transaction: idx=%h px=%h", dest_index, pixel_out);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (write_enable !== want.flags.write_enable
                    || dest_index !== want.dest_index
                    || pixel_out !== want.pixel
                    || end_of_source !== want.flags.end_of_source
                    || fit_error !== want.flags.fit_error)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch: want we=%0b idx=%h px=%h eos=%0b fe=%0b,",
                                  " got %0b %h %h %0b %0b"},
                                 want.flags.write_enable, want.dest_index, want.pixel,
                                 want.flags.end_of_source, want.flags.fit_error,
                                 write_enable, dest_index, pixel_out, end_of_source,
                                 fit_error);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        if (!sender_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(4, 24));
    endfunction

    // random pixel, alpha often right around the reference
    function automatic logic [akrb_pkg::PIXEL_W-1:0] random_pixel();
        logic [akrb_pkg::PIXEL_W-1:0] p;
        int                           a;
        p = $urandom;
        if ($urandom_range(0, 3) == 0)
        begin
            a = int'(blit_regs.alpha_ref) - 1 + int'($urandom_range(0, 2));
            if (a < 0)
                a = 0;
            if (a > 255)
                a = 255;
            p[31:24] = a[7:0];
        end
        return p;
    endfunction

    // one pixel transaction; valid stays high for a back-to-back follower
    task automatic send_pixel(input logic [akrb_pkg::PIXEL_W-1:0] px);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        source_pixel <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        queue_expected(place_pixel(px));
    endtask

    // stop sending and wait until every predicted write has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // one register write, valid left high for the next write
    task automatic put_reg(input akrb_pkg::reg_idx_t idx,
                           input logic [akrb_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // unused upper bits of a narrow register carry junk that must be ignored
    function automatic logic [akrb_pkg::CFG_DATA_W-1:0] with_junk(
        input logic [akrb_pkg::CFG_DATA_W-1:0] v,
        input int bits);
        logic [akrb_pkg::CFG_DATA_W-1:0] keep;
        keep = (akrb_pkg::CFG_DATA_W'(1) << bits) - akrb_pkg::CFG_DATA_W'(1);
        return (akrb_pkg::CFG_DATA_W'($urandom) & ~keep) | (v & keep);
    endfunction

    // write the whole register file; only called while the block is idle
    task automatic load_setup(input akrb_pkg::cfg_t c);
        put_reg(akrb_pkg::REG_DEST_WIDTH, c.dest_width);
        put_reg(akrb_pkg::REG_DEST_HEIGHT, c.dest_height);
        put_reg(akrb_pkg::REG_SOURCE_WIDTH, c.source_width);
        put_reg(akrb_pkg::REG_SOURCE_HEIGHT, c.source_height);
        put_reg(akrb_pkg::REG_OFFSET_X,
                with_junk(akrb_pkg::CFG_DATA_W'(c.offset_x), akrb_pkg::OFS_W));
        put_reg(akrb_pkg::REG_OFFSET_Y,
                with_junk(akrb_pkg::CFG_DATA_W'(c.offset_y), akrb_pkg::OFS_W));
        put_reg(akrb_pkg::REG_ALPHA_REF,
                with_junk(akrb_pkg::CFG_DATA_W'(c.alpha_ref), akrb_pkg::ALPHA_W));
        put_reg(akrb_pkg::REG_ROTATE, with_junk(akrb_pkg::CFG_DATA_W'(c.rotate), 1));
        cfg_valid <= 1'b0;
        blit_regs = c;
    endtask

    function automatic akrb_pkg::cfg_t make_setup(input int dw, dh, sw, sh, ox, oy, aref, rot);
        akrb_pkg::cfg_t c;
        c.dest_width    = akrb_pkg::DIM_W'(dw);
        c.dest_height   = akrb_pkg::DIM_W'(dh);
        c.source_width  = akrb_pkg::DIM_W'(sw);
        c.source_height = akrb_pkg::DIM_W'(sh);
        c.offset_x      = akrb_pkg::OFS_W'(ox);
        c.offset_y      = akrb_pkg::OFS_W'(oy);
        c.alpha_ref     = akrb_pkg::ALPHA_W'(aref);
        c.rotate        = 1'(rot);
        return c;
    endfunction

    // mostly tiny rectangles, now and then zero, oversized or anything legal
    function automatic logic [akrb_pkg::DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 12)
            return akrb_pkg::DIM_W'($urandom_range(MAX_DIM + 1, 2047));
        if (r < 20)
            return akrb_pkg::DIM_W'($urandom_range(1, MAX_DIM));
        return akrb_pkg::DIM_W'($urandom_range(1, 6));
    endfunction

    function automatic logic [akrb_pkg::OFS_W-1:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return akrb_pkg::OFS_W'($urandom_range(0, 5));
        if (r < 85)
            return akrb_pkg::OFS_W'($urandom_range(0, 1023));
        if (r < 92)
            return akrb_pkg::OFS_W'(1023);
        return '0;
    endfunction

    function automatic akrb_pkg::cfg_t random_setup();
        akrb_pkg::cfg_t c;
        int unsigned    need_w, need_h;
        c.source_width  = pick_dim();
        c.source_height = pick_dim();
        c.rotate        = 1'($urandom_range(0, 1));
        c.offset_x      = pick_offset();
        c.offset_y      = pick_offset();
        case ($urandom_range(0, 9))
            0:       c.alpha_ref = '0;
            1:       c.alpha_ref = akrb_pkg::ALPHA_W'($urandom_range(256, 511));
            default: c.alpha_ref = akrb_pkg::ALPHA_W'($urandom_range(0, 255));
        endcase
        need_w = 32'(c.offset_x) + clamp_dim(c.rotate ? c.source_height : c.source_width);
        need_h = 32'(c.offset_y) + clamp_dim(c.rotate ? c.source_width : c.source_height);
        if ($urandom_range(0, 3) != 0)
        begin
            // mostly a placement that fits, with a little slack
            c.dest_width  = (need_w > MAX_DIM) ? akrb_pkg::DIM_W'(MAX_DIM)
                                               : akrb_pkg::DIM_W'(need_w + $urandom_range(0, 2));
            c.dest_height = (need_h > MAX_DIM) ? akrb_pkg::DIM_W'(MAX_DIM)
                                               : akrb_pkg::DIM_W'(need_h + $urandom_range(0, 2));
        end
        else
        begin
            c.dest_width  = pick_dim();
            c.dest_height = pick_dim();
        end
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset registers: 1x1 source, every pixel closes the rectangle
    task automatic test_reset_defaults();
        sender_gaps = 1'b0;
        stall_mode <= 0;
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h5A00_00A5);
        drain();
    endtask

    task automatic test_corner_cases();
        sender_gaps = 1'b1;
        stall_mode <= 1;
        // zero dimensions act as one
        load_setup(make_setup(0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'hFF00_0000);
        drain();
        // oversized dimensions clamp, alpha reference 256 blocks every write
        load_setup(make_setup(2047, 2047, 2047, 2047, 0, 0, 256, 1));
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFF12_3456);
        drain();
        // alpha reference with every bit set, counter past the new width
        load_setup(make_setup(1024, 1024, 2, 1, 0, 0, 511, 0));
        send_pixel(32'hFFAB_CDEF);
        drain();
        // bottom right corner of the surface, alpha just below and at the reference
        load_setup(make_setup(1024, 1024, 1, 1, 1023, 1023, 128, 0));
        send_pixel(32'h7FFF_FFFF);
        send_pixel(32'h8000_0000);
        drain();
        // one column too wide: fit error, and the index wraps past the port width
        load_setup(make_setup(1024, 1024, 2, 1, 1023, 1023, 0, 0));
        send_pixel(32'hFF00_0001);
        send_pixel(32'hFF00_0002);
        drain();
        // transposed copy that only fits because of the swap
        load_setup(make_setup(2, 3, 3, 2, 0, 0, 0, 1));
        repeat (6) send_pixel($urandom);
        drain();
        // same placement straight leaves the surface
        load_setup(make_setup(2, 3, 3, 2, 0, 0, 0, 0));
        send_pixel($urandom);
        send_pixel($urandom);
        drain();
    endtask

    // dimensions shrink while the raster position sits past the new limits
    task automatic test_shrink_mid_stream();
        sender_gaps = 1'b1;
        stall_mode <= 1;
        load_setup(make_setup(64, 64, 5, 4, 3, 2, 0, 0));
        while (src_col != 0 || src_row != 0)
            send_pixel(random_pixel());
        repeat (13) send_pixel(random_pixel());
        drain();
        // column 3, row 2 against a 2x2 source: both counters wrap at once
        load_setup(make_setup(64, 64, 2, 2, 3, 2, 0, 0));
        repeat (5) send_pixel(random_pixel());
        drain();
        load_setup(make_setup(64, 64, 5, 4, 0, 0, 0, 1));
        while (src_col != 0 || src_row != 0)
            send_pixel(random_pixel());
        repeat (8) send_pixel(random_pixel());
        drain();
        // only the width shrinks, the row keeps counting
        load_setup(make_setup(64, 64, 2, 4, 0, 0, 0, 1));
        repeat (6) send_pixel(random_pixel());
        drain();
    endtask

    // full size source rectangles placed against the far edge of the surface
    task automatic test_large_placement();
        sender_gaps = 1'b0;
        stall_mode <= 0;
        load_setup(make_setup(1024, 1024, 1024, 2, 0, 1022, 128, 0));
        repeat (40) send_pixel(random_pixel());
        drain();
        sender_gaps = 1'b1;
        stall_mode <= 1;
        load_setup(make_setup(1024, 2047, 1024, 2, 1022, 0, 128, 1));
        repeat (40) send_pixel(random_pixel());
        drain();
    endtask

    // heavy receiver stalls against a sender that never idles
    task automatic test_back_pressure();
        sender_gaps = 1'b0;
        stall_mode <= 2;
        load_setup(make_setup(16, 16, 3, 3, 1, 1, 64, 0));
        repeat (30) send_pixel(random_pixel());
        // hold the sender until every outstanding transaction has drained
        drain();
        repeat (30) send_pixel(random_pixel());
        drain();
    endtask

    // random register settings, mostly whole rectangles of random pixels
    task automatic test_random_blits();
        akrb_pkg::cfg_t c;
        int             sent, n, area;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            c = random_setup();
            load_setup(c);
            // some phases run with one or both sides never idling
            sender_gaps = ($urandom_range(0, 4) != 0);
            stall_mode <= ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 2));
            area = int'(clamp_dim(c.source_width) * clamp_dim(c.source_height));
            if (area <= 36 && $urandom_range(0, 3) != 0)
                n = area * int'($urandom_range(1, 3));
            else
                n = int'($urandom_range(1, 40));
            repeat (n) send_pixel(random_pixel());
            sent += n;
            drain();
        end
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin : run
        int settle;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_corner_cases();
        test_shrink_mid_stream();
        test_large_placement();
        test_back_pressure();
        test_random_blits();

        // wait out anything still in flight, bounded
        in_valid <= 1'b0;
        for (settle = 0; settle < 20000 && pending_writes.size() != 0; settle++)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (pending_writes.size() != 0)
        begin
            $display("missing transactions: %0d", pending_writes.size());
            fault_count += pending_writes.size();
        end

        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
